// ----- hdl/minv_pkg.sv -----
// Package for the modular inverse block: microcode opcodes, control word
// layout, the microcode program and the divider control struct.
// No dependencies.
`default_nettype none

package minv_pkg;

    localparam int DEF_MOD_WIDTH = 31;
    localparam int VAL_W         = 32;
    localparam int PC_W          = 3;
    localparam int OP_W          = 3;
    localparam int CNT_W         = $clog2(VAL_W + 1);

    // Micro-ops
    localparam logic [OP_W-1:0] UOP_WAIT   = 3'd0;
    localparam logic [OP_W-1:0] UOP_DIV    = 3'd1;
    localparam logic [OP_W-1:0] UOP_SETUP  = 3'd2;
    localparam logic [OP_W-1:0] UOP_TEST   = 3'd3;
    localparam logic [OP_W-1:0] UOP_STEP   = 3'd4;
    localparam logic [OP_W-1:0] UOP_FIXNEG = 3'd5;
    localparam logic [OP_W-1:0] UOP_FIXOUT = 3'd6;

    // Program addresses
    localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
    localparam logic [PC_W-1:0] PC_RED    = 3'd1;
    localparam logic [PC_W-1:0] PC_SETUP  = 3'd2;
    localparam logic [PC_W-1:0] PC_TEST   = 3'd3;
    localparam logic [PC_W-1:0] PC_DIV    = 3'd4;
    localparam logic [PC_W-1:0] PC_STEP   = 3'd5;
    localparam logic [PC_W-1:0] PC_FIXNEG = 3'd6;
    localparam logic [PC_W-1:0] PC_FIXOUT = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [PC_W-1:0] target;   // taken jump address
    } t_uop;

    typedef struct packed {
        logic load;       // start a new division
        logic run;        // one quotient bit
        logic long_len;   // full value width instead of modulus width
    } t_div_ctl;

    // Microcode ROM
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop w;
        case (pc)
            PC_WAIT:   w = '{op: UOP_WAIT,   target: PC_RED};
            PC_RED:    w = '{op: UOP_DIV,    target: PC_SETUP};
            PC_SETUP:  w = '{op: UOP_SETUP,  target: PC_TEST};
            PC_TEST:   w = '{op: UOP_TEST,   target: PC_FIXNEG};
            PC_DIV:    w = '{op: UOP_DIV,    target: PC_STEP};
            PC_STEP:   w = '{op: UOP_STEP,   target: PC_TEST};
            PC_FIXNEG: w = '{op: UOP_FIXNEG, target: PC_FIXOUT};
            PC_FIXOUT: w = '{op: UOP_FIXOUT, target: PC_WAIT};
            default:   w = '{op: UOP_WAIT,   target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/modular_inverse_top.sv -----
// Modular inverse top level: microcoded sequencer over the Euclid
// registers, driving the serial divider. Depends on minv_pkg, minv_div_unit.
`default_nettype none

//  channel | ports                         | handshake
//  --------+-------------------------------+-------------------------------
//  request | i_value, i_modulus            | start & !busy accepts
//  result  | o_inverse                     | o_valid, one cycle, no stall
//
//  A request runs the reduction of i_value over the full value width, the
//  setup, then per Euclid step a test, a division over the modulus width
//  and an update, then the final test, sign fix and output. The serial
//  divider, one quotient bit a cycle, sets the running time.
//  Reset (i_rst_n low, synchronous) returns the sequencer to idle and
//  drops o_valid. The result cannot be stalled: o_valid pulses once, and
//  busy is already low in that cycle so the next request may start.

module modular_inverse_top #(
    parameter int MOD_WIDTH = minv_pkg::DEF_MOD_WIDTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output      logic                        busy,
    input  wire logic [minv_pkg::VAL_W-1:0]  i_value,
    input  wire logic [MOD_WIDTH-1:0]        i_modulus,
    output      logic                        o_valid,
    output      logic [MOD_WIDTH-1:0]        o_inverse
);
    import minv_pkg::*;

    localparam int X_W = MOD_WIDTH + 2;

    // Sequencer
    logic [PC_W-1:0]        r_pc;
    logic [PC_W-1:0]        n_pc;
    t_uop                   uop;

    // Euclid state: remainders r0/r1, cofactors x0/x1, the modulus p
    logic [MOD_WIDTH-1:0]   r_p;
    logic [MOD_WIDTH-1:0]   r_r0;
    logic [MOD_WIDTH-1:0]   r_r1;
    logic signed [X_W-1:0]  r_x0;
    logic signed [X_W-1:0]  r_x1;
    logic                   r_valid;
    logic [MOD_WIDTH-1:0]   r_out;

    // Divider hookup
    t_div_ctl               div_ctl;
    logic [VAL_W-1:0]       div_num;
    logic [MOD_WIDTH-1:0]   div_rem;
    logic signed [X_W-1:0]  div_acc;
    logic                   div_last;

    logic                   accept;
    logic signed [X_W-1:0]  p_ext;
    logic signed [X_W-1:0]  x1_minus_p;

    assign uop        = uop_rom(r_pc);
    assign busy       = (r_pc != PC_WAIT);
    assign accept     = start && !busy;
    assign p_ext      = $signed({2'b00, r_p});
    assign x1_minus_p = r_x1 - p_ext;

    // r0 goes to the top of the dividend so only MOD_WIDTH bits are walked
    always_comb begin
        if (uop.op == UOP_WAIT) begin
            div_num = i_value;
        end else begin
            div_num = {r_r0, {(VAL_W - MOD_WIDTH){1'b0}}};
        end
    end

    // Control word decode: divider strobes and next step
    always_comb begin
        div_ctl = '{load: 1'b0, run: 1'b0, long_len: 1'b0};
        n_pc    = r_pc;
        case (uop.op)
            UOP_WAIT: begin
                if (accept) begin
                    div_ctl.load     = 1'b1;
                    div_ctl.long_len = 1'b1;
                    n_pc             = uop.target;
                end
            end
            UOP_DIV: begin
                div_ctl.run = 1'b1;
                if (div_last) begin
                    n_pc = uop.target;
                end
            end
            UOP_TEST: begin
                // stop once the newest remainder is 1 or less
                if (r_r1 <= MOD_WIDTH'(1)) begin
                    n_pc = uop.target;
                end else begin
                    div_ctl.load = 1'b1;
                    n_pc         = r_pc + 1'b1;
                end
            end
            UOP_SETUP, UOP_STEP, UOP_FIXNEG, UOP_FIXOUT: begin
                n_pc = uop.target;
            end
            default: begin
                n_pc = PC_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= PC_WAIT;
            r_valid <= 1'b0;
        end else begin
            r_pc    <= n_pc;
            r_valid <= (uop.op == UOP_FIXOUT);
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (uop.op)
            UOP_WAIT: begin
                if (accept) begin
                    r_p  <= i_modulus;
                    r_r0 <= i_modulus;
                    r_r1 <= i_modulus;   // divisor for the first reduction
                    r_x0 <= '0;
                    r_x1 <= X_W'(1);
                end
            end
            UOP_SETUP: begin
                // zero modulus: force remainder and cofactor to zero
                if (r_p == '0) begin
                    r_r1 <= '0;
                    r_x1 <= '0;
                end else begin
                    r_r1 <= div_rem;
                end
            end
            UOP_STEP: begin
                r_r0 <= r_r1;
                r_r1 <= div_rem;
                r_x0 <= r_x1;
                r_x1 <= r_x0 - div_acc;   // x0 - q*x1
            end
            UOP_FIXNEG: begin
                if (r_x1 < 0) begin
                    r_x1 <= r_x1 + p_ext;
                end
            end
            UOP_FIXOUT: begin
                // cofactor is at most p in magnitude, so one subtract suffices
                if (r_x1 >= p_ext) begin
                    r_out <= x1_minus_p[MOD_WIDTH-1:0];
                end else begin
                    r_out <= r_x1[MOD_WIDTH-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    minv_div_unit #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (div_num),
        .i_den   (r_r1),
        .i_mult  (r_x1),
        .o_rem   (div_rem),
        .o_acc   (div_acc),
        .o_last  (div_last)
    );

    assign o_valid   = r_valid;
    assign o_inverse = r_out;

    // Result strobe lands with the sequencer back at idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_pc == PC_WAIT)
        else $error("result strobe while busy");

    // An accepted request makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request accepted but not busy");

    // Result lies below a nonzero modulus.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_p != '0) |-> r_out < r_p)
        else $error("result out of range");

    // Strobe is one cycle wide.
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

// ----- hdl/minv_div_unit.sv -----
// Shift-subtract divider, one quotient bit per cycle while i_ctl.run is set,
// that also folds the quotient times a cofactor into an accumulator (Horner,
// MSB first). Depends on minv_pkg.
`default_nettype none

module minv_div_unit #(
    parameter int MOD_WIDTH = minv_pkg::DEF_MOD_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire minv_pkg::t_div_ctl              i_ctl,
    input  wire logic [minv_pkg::VAL_W-1:0]      i_num,
    input  wire logic [MOD_WIDTH-1:0]            i_den,
    input  wire logic signed [MOD_WIDTH+1:0]     i_mult,
    output      logic [MOD_WIDTH-1:0]            o_rem,
    output      logic signed [MOD_WIDTH+1:0]     o_acc,
    output      logic                            o_last
);
    import minv_pkg::*;

    localparam int X_W = MOD_WIDTH + 2;

    logic [VAL_W-1:0]        r_num;
    logic [MOD_WIDTH-1:0]    r_rem;
    logic signed [X_W-1:0]   r_acc;
    logic [CNT_W-1:0]        r_cnt;

    logic [MOD_WIDTH:0]      n_trial;
    logic                    n_ge;
    logic [MOD_WIDTH:0]      n_diff;
    logic [MOD_WIDTH-1:0]    n_rem;
    logic signed [X_W-1:0]   n_acc;

    always_comb begin
        n_trial = {r_rem, r_num[VAL_W-1]};
        n_ge    = n_trial >= {1'b0, i_den};
        n_diff  = n_trial - {1'b0, i_den};
        n_rem   = n_ge ? n_diff[MOD_WIDTH-1:0] : n_trial[MOD_WIDTH-1:0];
        n_acc   = (r_acc <<< 1) + (n_ge ? i_mult : {X_W{1'b0}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= i_ctl.long_len ? CNT_W'(VAL_W) : CNT_W'(MOD_WIDTH);
        end else if (i_ctl.run) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_num <= i_num;
            r_rem <= '0;
            r_acc <= '0;
        end else if (i_ctl.run) begin
            r_num <= r_num << 1;
            r_rem <= n_rem;
            r_acc <= n_acc;
        end
    end

    assign o_rem  = r_rem;
    assign o_acc  = r_acc;
    assign o_last = (r_cnt == CNT_W'(1));

    // A bit step is only issued while bits remain.
    a_run_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.run |-> r_cnt != '0)
        else $error("divider stepped with no bits left");

    // Load and step never coincide.
    a_load_xor_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.load && i_ctl.run))
        else $error("divider load and step together");

    // After a load the count is the chosen length.
    a_load_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |=> (r_cnt == CNT_W'(VAL_W) || r_cnt == CNT_W'(MOD_WIDTH)))
        else $error("divider count not loaded");

endmodule

`default_nettype wire
